[rtl/umc_pkg.sv]
// Shared types and constants for the unitary matrix check block.
// Used by umc_ctrl, umc_dp and unitary_matrix_check_unit; no dependencies.
`default_nettype none
package umc_pkg;

  localparam int ELEM_W  = 32;            // one real or imaginary part
  localparam int WORD_W  = 2 * ELEM_W;    // stored element: {imag, real}
  localparam int ACC_W   = 48;            // product accumulator
  localparam int TOL_W   = 31;
  localparam int QCFG_W  = 2;             // matrix_qubits register width
  localparam int APB_DW  = 32;
  localparam int APB_AW  = 3;
  localparam int REG_IDX_W = 1;

  localparam logic [REG_IDX_W-1:0] REG_QUBITS = 1'd0;
  localparam logic [REG_IDX_W-1:0] REG_TOL    = 1'd1;

  localparam logic [QCFG_W-1:0] QUBITS_RST = 2'd1;
  localparam logic [TOL_W-1:0]  TOL_RST    = 31'd1024;

  // controller -> datapath
  typedef struct packed {
    logic load;   // write the incoming element into the store
    logic start;  // last element loaded, arm the pass flag
    logic step;   // issue one multiply-accumulate term
    logic first;  // first term of a product entry
    logic last;   // last term of a product entry
    logic diag;   // entry sits on the diagonal
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic busy;   // terms still in flight
    logic pass;   // no entry has failed so far
  } dp_stat_t;

endpackage
`default_nettype wire

[rtl/umc_ctrl.sv]
// Controller for the unitary matrix check: load counter, product-entry
// sequencer state machine and the result register. Depends on umc_pkg.
`default_nettype none
module umc_ctrl #(
  parameter int MAX_QUBITS = 3
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic [$clog2(MAX_QUBITS+1)-1:0]    q_eff,
  input  wire logic                               cfg_clear,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  output umc_pkg::dp_cmd_t                        cmd,
  output logic [2*MAX_QUBITS-1:0]                 wr_addr,
  output logic [2*MAX_QUBITS-1:0]                 rd_addr_a,
  output logic [2*MAX_QUBITS-1:0]                 rd_addr_b,
  input  wire umc_pkg::dp_stat_t                  stat,
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  output logic                                    out_is_unitary
);
  import umc_pkg::*;

  localparam int QW = MAX_QUBITS;
  localparam int AW = 2 * MAX_QUBITS;
  localparam int CW = AW + 1;

  typedef enum logic [2:0] {
    ST_LOAD  = 3'b001,
    ST_CHECK = 3'b010,
    ST_DRAIN = 3'b100
  } state_t;

  state_t        state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [QW-1:0] i_r, i_nxt, c_r, c_nxt, r_r, r_nxt;
  logic          out_tvalid_r, out_tvalid_nxt;
  logic          out_data_r;

  logic [QW-1:0] mask;
  logic [CW-1:0] total;
  logic [CW-1:0] cnt_eff;
  logic          load_last;
  logic          accept;
  logic          i_last, c_last, r_last, end_all;
  logic          out_free;
  logic          emit;

  assign mask      = QW'((32'd1 << q_eff) - 32'd1);
  assign total     = CW'(1) << {q_eff, 1'b0};
  assign cnt_eff   = (count_r >= total) ? '0 : count_r;
  assign load_last = (cnt_eff == total - CW'(1));
  assign in_tready = (state_r == ST_LOAD);
  assign accept    = in_tvalid && in_tready;

  assign i_last  = (i_r == mask);
  assign c_last  = (c_r == mask);
  assign r_last  = (r_r == mask);
  assign end_all = i_last && c_last && r_last;

  assign out_free = !out_tvalid_r || out_tready;
  assign emit     = (state_r == ST_DRAIN) && !stat.busy && out_free;

  assign wr_addr   = cnt_eff[AW-1:0];
  assign rd_addr_a = (AW'(r_r) << q_eff) | AW'(i_r);
  assign rd_addr_b = (AW'(c_r) << q_eff) | AW'(i_r);

  always_comb begin
    cmd.load  = accept;
    cmd.start = accept && load_last;
    cmd.step  = (state_r == ST_CHECK);
    cmd.first = (i_r == '0);
    cmd.last  = i_last;
    cmd.diag  = (r_r == c_r);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_LOAD:  if (accept && load_last) state_nxt = ST_CHECK;
      ST_CHECK: if (end_all) state_nxt = ST_DRAIN;
      ST_DRAIN: if (emit) state_nxt = ST_LOAD;
      default:  state_nxt = ST_LOAD;
    endcase
  end

  // load counter; a size change drops a partly loaded matrix
  always_comb begin
    count_nxt = count_r;
    if (cfg_clear) begin
      count_nxt = '0;
    end else if (accept) begin
      count_nxt = load_last ? '0 : cnt_eff + CW'(1);
    end
  end

  // i runs fastest, then column, then row
  always_comb begin
    i_nxt = '0;
    c_nxt = '0;
    r_nxt = '0;
    if (state_r == ST_CHECK) begin
      i_nxt = i_last ? '0 : i_r + QW'(1);
      c_nxt = c_r;
      r_nxt = r_r;
      if (i_last) begin
        c_nxt = c_last ? '0 : c_r + QW'(1);
        if (c_last) begin
          r_nxt = r_last ? '0 : r_r + QW'(1);
        end
      end
    end
  end

  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    if (emit) begin
      out_tvalid_nxt = 1'b1;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_LOAD;
      count_r      <= '0;
      i_r          <= '0;
      c_r          <= '0;
      r_r          <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      i_r          <= i_nxt;
      c_r          <= c_nxt;
      r_r          <= r_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r <= stat.pass;
    end
  end

  assign out_tvalid     = out_tvalid_r;
  assign out_is_unitary = out_data_r;

  a_load_to_check: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |=> state_r == ST_CHECK)
    else $error("last element did not start the check");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r < total)
    else $error("load count beyond matrix size");

  a_idx_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_CHECK |-> (i_r == '0 && c_r == '0 && r_r == '0))
    else $error("entry counters not parked outside check");

  a_emit: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> out_tvalid_r)
    else $error("drained check did not present a result");

endmodule
`default_nettype wire

[rtl/umc_dp.sv]
// Datapath for the unitary matrix check: element store, complex
// multiply-accumulate pipeline and tolerance compare. Depends on umc_pkg.
`default_nettype none
module umc_dp #(
  parameter int MAX_QUBITS = 3,
  parameter int FRAC_BITS  = 30
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire umc_pkg::dp_cmd_t              cmd,
  input  wire logic [2*MAX_QUBITS-1:0]       wr_addr,
  input  wire logic [2*MAX_QUBITS-1:0]       rd_addr_a,
  input  wire logic [2*MAX_QUBITS-1:0]       rd_addr_b,
  input  wire logic [umc_pkg::WORD_W-1:0]    wr_data,
  input  wire logic [umc_pkg::TOL_W-1:0]     tol,
  output umc_pkg::dp_stat_t                  stat
);
  import umc_pkg::*;

  localparam int DEPTH = 1 << (2 * MAX_QUBITS);
  localparam int PW    = 2 * ELEM_W;   // full product
  localparam int DW    = ACC_W + 2;    // deviation, room for sign and offset

  logic [WORD_W-1:0] mem [DEPTH];

  logic [WORD_W-1:0] a_r, b_r;
  logic              v1_r, v2_r, v3_r, v4_r;
  logic              f1_r, l1_r, d1_r, f2_r, l2_r, d2_r, l3_r, d3_r;
  logic signed [PW-1:0] pp_rr_r, pp_ii_r, pp_ir_r, pp_ri_r;
  logic [ACC_W-1:0]  acc_re_r, acc_im_r;
  logic signed [DW-1:0] dev_re_r, dev_im_r;
  logic              pass_r;

  logic signed [PW-1:0] sh_rr, sh_ii, sh_ir, sh_ri;
  logic [ACC_W-1:0]  base_re, base_im, acc_re_nxt, acc_im_nxt;
  logic signed [DW-1:0] target, tol_s, neg_tol, acc_re_s, acc_im_s;
  logic              fail;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      a_r  <= mem[rd_addr_a];
      b_r  <= mem[rd_addr_b];
      f1_r <= cmd.first;
      l1_r <= cmd.last;
      d1_r <= cmd.diag;
    end
  end

  // row a times conj(row b): four real products
  always_ff @(posedge clk) begin
    if (v1_r) begin
      pp_rr_r <= $signed(a_r[ELEM_W-1:0])      * $signed(b_r[ELEM_W-1:0]);
      pp_ii_r <= $signed(a_r[WORD_W-1:ELEM_W]) * $signed(b_r[WORD_W-1:ELEM_W]);
      pp_ir_r <= $signed(a_r[WORD_W-1:ELEM_W]) * $signed(b_r[ELEM_W-1:0]);
      pp_ri_r <= $signed(a_r[ELEM_W-1:0])      * $signed(b_r[WORD_W-1:ELEM_W]);
      f2_r    <= f1_r;
      l2_r    <= l1_r;
      d2_r    <= d1_r;
    end
  end

  // floor to FRAC_BITS, then wrap into the accumulator
  always_comb begin
    sh_rr      = pp_rr_r >>> FRAC_BITS;
    sh_ii      = pp_ii_r >>> FRAC_BITS;
    sh_ir      = pp_ir_r >>> FRAC_BITS;
    sh_ri      = pp_ri_r >>> FRAC_BITS;
    base_re    = f2_r ? '0 : acc_re_r;
    base_im    = f2_r ? '0 : acc_im_r;
    acc_re_nxt = base_re + sh_rr[ACC_W-1:0] + sh_ii[ACC_W-1:0];
    acc_im_nxt = base_im + sh_ir[ACC_W-1:0] - sh_ri[ACC_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (v2_r) begin
      acc_re_r <= acc_re_nxt;
      acc_im_r <= acc_im_nxt;
      l3_r     <= l2_r;
      d3_r     <= d2_r;
    end
  end

  assign target   = DW'(1) << FRAC_BITS;
  assign acc_re_s = $signed({{(DW-ACC_W){acc_re_r[ACC_W-1]}}, acc_re_r});
  assign acc_im_s = $signed({{(DW-ACC_W){acc_im_r[ACC_W-1]}}, acc_im_r});

  always_ff @(posedge clk) begin
    if (v3_r && l3_r) begin
      dev_re_r <= acc_re_s - (d3_r ? target : DW'(0));
      dev_im_r <= acc_im_s;
    end
  end

  // |x| > tol is the same as x > tol or x < -tol
  assign tol_s   = $signed({{(DW-TOL_W){1'b0}}, tol});
  assign neg_tol = -tol_s;
  assign fail    = (dev_re_r > tol_s) || (dev_re_r < neg_tol) ||
                   (dev_im_r > tol_s) || (dev_im_r < neg_tol);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      v3_r   <= 1'b0;
      v4_r   <= 1'b0;
      pass_r <= 1'b1;
    end else begin
      v1_r <= cmd.step;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r && l3_r;
      if (cmd.start) begin
        pass_r <= 1'b1;
      end else if (v4_r && fail) begin
        pass_r <= 1'b0;
      end
    end
  end

  always_comb begin
    stat.busy = v1_r || v2_r || v3_r || v4_r;
    stat.pass = pass_r;
  end

endmodule
`default_nettype wire

[rtl/unitary_matrix_check_unit.sv]
// Unitary matrix check: loads 2^q x 2^q complex elements row-major, then
// checks M * M^H against identity within a tolerance and sends one flag.
// The flag is sent once all terms have left the pipeline and the output is free;
// one multiply-accumulate term of M * M^H is issued per cycle of the check, and input
// is held off during the check. Synchronous active-low reset clears control,
// sets matrix_qubits to 1 and tolerance to 1024; store contents are not reset.
`default_nettype none
module unitary_matrix_check_unit #(
  parameter int MAX_QUBITS = 3,
  parameter int FRAC_BITS  = 30
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  input  wire logic [63:0]                    in_tdata,   // [31:0] elem_real, [63:32] elem_imag
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  output logic [7:0]                          out_tdata,  // [0] is_unitary, [7:1] zero
  input  wire logic                           cfg_psel,
  input  wire logic                           cfg_penable,
  input  wire logic                           cfg_pwrite,
  input  wire logic [umc_pkg::APB_AW-1:0]     cfg_paddr,
  input  wire logic [umc_pkg::APB_DW-1:0]     cfg_pwdata,
  output logic [umc_pkg::APB_DW-1:0]          cfg_prdata,
  output logic                                cfg_pready
);
  import umc_pkg::*;

  localparam int QBW = $clog2(MAX_QUBITS + 1);
  localparam int AW  = 2 * MAX_QUBITS;

  logic [QCFG_W-1:0]    qubits_r;
  logic [TOL_W-1:0]     tol_r;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 cfg_wr;
  logic                 cfg_clear;
  logic [QBW-1:0]       q_eff;

  dp_cmd_t              cmd;
  dp_stat_t             stat;
  logic [AW-1:0]        wr_addr, rd_addr_a, rd_addr_b;
  logic                 is_unitary;

  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[2 +: REG_IDX_W];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_clear  = cfg_wr && (reg_idx == REG_QUBITS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qubits_r <= QUBITS_RST;
      tol_r    <= TOL_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_QUBITS: qubits_r <= cfg_pwdata[QCFG_W-1:0];
        REG_TOL:    tol_r    <= cfg_pwdata[TOL_W-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_QUBITS: cfg_prdata = APB_DW'(qubits_r);
      REG_TOL:    cfg_prdata = APB_DW'(tol_r);
      default:    cfg_prdata = '0;
    endcase
  end

  // sizes above what the store holds saturate
  assign q_eff = (32'(qubits_r) > MAX_QUBITS) ? QBW'(MAX_QUBITS) : QBW'(qubits_r);

  umc_ctrl #(
    .MAX_QUBITS (MAX_QUBITS)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_eff          (q_eff),
    .cfg_clear      (cfg_clear),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .cmd            (cmd),
    .wr_addr        (wr_addr),
    .rd_addr_a      (rd_addr_a),
    .rd_addr_b      (rd_addr_b),
    .stat           (stat),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_is_unitary (is_unitary)
  );

  umc_dp #(
    .MAX_QUBITS (MAX_QUBITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .wr_addr   (wr_addr),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .wr_data   (in_tdata),
    .tol       (tol_r),
    .stat      (stat)
  );

  assign out_tdata = {7'd0, is_unitary};

endmodule
`default_nettype wire

[tb/tb.sv]
// Self-checking bench for unitary_matrix_check_unit: stream matrices in, check the flags.
// Keeps its own fixed-point model of M * M^H against identity.
// Depends on umc_pkg and the unitary_matrix_check_unit RTL.
`timescale 1ns / 100ps
module tb;
  import umc_pkg::*;

  localparam int MAX_Q       = 3;
  localparam int FRAC        = 30;
  localparam int STORE_N     = 1 << (2 * MAX_Q);
  localparam int DRAIN_WAIT  = 600;        // lets the check pipeline empty for dim 8
  localparam int CYCLE_LIMIT = 1000000;
  localparam logic signed [ELEM_W-1:0] ONE  = 32'sd1073741824;
  localparam logic signed [ELEM_W-1:0] HALF_SQRT2 = 32'sd759250125;  // 2^30 / sqrt(2)

  typedef struct packed {
    logic signed [ELEM_W-1:0] im_part;
    logic signed [ELEM_W-1:0] re_part;
  } elem_t;

  typedef enum int {MAT_PHASE_PERM, MAT_BALANCED, MAT_EXTREME, MAT_NOISE} mat_kind_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [WORD_W-1:0] in_tdata = '0;       // [31:0] elem_real, [63:32] elem_imag
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [7:0] out_tdata;                  // [0] is_unitary, [7:1] zero
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [APB_AW-1:0] cfg_paddr = '0;
  logic [APB_DW-1:0] cfg_pwdata = '0;
  logic [APB_DW-1:0] cfg_prdata;
  logic cfg_pready;

  unitary_matrix_check_unit dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial forever #6 clk = ~clk;

  // model state
  logic [WORD_W-1:0] elem_store [STORE_N];
  int unsigned       loaded = 0;
  logic [QCFG_W-1:0] qubits_cfg = QUBITS_RST;
  logic [TOL_W-1:0]  tol_cfg = TOL_RST;

  elem_t elem_q[$];
  bit    unitary_q[$];
  bit    calm = 1'b0;
  bit    in_taken = 1'b0;
  int    fail_count = 0;
  int    flags_seen = 0;
  int    items_queued = 0;
  int    cycle_count = 0;

  task automatic log_fail(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endtask

  function automatic bit product_near_identity(input int dim);
    logic signed [ACC_W-1:0] acc_re, acc_im;
    logic [WORD_W-1:0] a, b;
    longint ar, ai, br, bi, re_v, im_v, tol;
    tol = tol_cfg;
    for (int r = 0; r < dim; r++) begin
      for (int c = 0; c < dim; c++) begin
        acc_re = '0;
        acc_im = '0;
        for (int i = 0; i < dim; i++) begin
          a = elem_store[(r * dim + i) % STORE_N];
          b = elem_store[(c * dim + i) % STORE_N];
          ar = $signed(a[ELEM_W-1:0]);
          ai = $signed(a[WORD_W-1:ELEM_W]);
          br = $signed(b[ELEM_W-1:0]);
          bi = $signed(b[WORD_W-1:ELEM_W]);
          // each product floors to FRAC fractional bits, the sum wraps at ACC_W
          acc_re = acc_re + ((ar * br) >>> FRAC) + ((ai * bi) >>> FRAC);
          acc_im = acc_im + ((ai * br) >>> FRAC) - ((ar * bi) >>> FRAC);
        end
        re_v = acc_re;
        im_v = acc_im;
        if (r == c) re_v = re_v - longint'(ONE);
        if (re_v < 0) re_v = -re_v;
        if (im_v < 0) im_v = -im_v;
        if (im_v > tol || re_v > tol) return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  function automatic void take_element(input logic [WORD_W-1:0] word);
    int q, dim, total;
    q = (qubits_cfg > MAX_Q) ? MAX_Q : qubits_cfg;
    dim = 1 << q;
    total = dim * dim;
    if (loaded >= total) loaded = 0;
    elem_store[loaded % STORE_N] = word;
    loaded++;
    if (loaded == total) begin
      loaded = 0;
      unitary_q.push_back(product_near_identity(dim));
    end
  endfunction

  // driver: inputs change on the falling edge
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      out_tready <= 1'b0;
    end else begin
      out_tready <= calm || ($urandom_range(99) >= 8);
      if (!in_tvalid || in_taken) begin
        if (elem_q.size() != 0 && (calm || $urandom_range(99) >= 8)) begin
          in_tvalid <= 1'b1;
          in_tdata <= elem_q.pop_front();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: sample on the rising edge
  always @(posedge clk) begin
    bit want;
    in_taken <= rst_n && in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready) take_element(in_tdata);
    if (rst_n && out_tvalid && out_tready) begin
      flags_seen++;
      if (unitary_q.size() == 0) begin
        log_fail($sformatf("flag transfer %h with none expected", out_tdata));
      end else begin
        want = unitary_q.pop_front();
        if (out_tdata !== {7'b0, want})
          log_fail($sformatf("is_unitary flag %0d: expected %h, got %h",
                             flags_seen, {7'b0, want}, out_tdata));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic logic [APB_AW-1:0] reg_addr(input logic [REG_IDX_W-1:0] idx);
    return {idx, 2'b00};
  endfunction

  task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input logic [APB_DW-1:0] data);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= reg_addr(idx);
    cfg_pwdata <= data;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    if (idx == REG_QUBITS) begin
      qubits_cfg = data[QCFG_W-1:0];
      loaded = 0;
    end else if (idx == REG_TOL) begin
      tol_cfg = data[TOL_W-1:0];
    end
  endtask

  task automatic reg_check(input logic [REG_IDX_W-1:0] idx);
    logic [APB_DW-1:0] want;
    want = (idx == REG_QUBITS) ? APB_DW'(qubits_cfg) : APB_DW'(tol_cfg);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= reg_addr(idx);
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (cfg_prdata !== want)
      log_fail($sformatf("register %0d readback: expected %h, got %h", idx, want, cfg_prdata));
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // wait until every transfer is done and no flag is outstanding, then let the
  // check pipeline empty before touching the registers
  task automatic settle();
    @(posedge clk);
    while (elem_q.size() != 0 || in_tvalid || unitary_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic queue_one(input logic [ELEM_W-1:0] re, input logic [ELEM_W-1:0] im);
    elem_q.push_back({im, re});
  endtask

  function automatic logic [ELEM_W-1:0] pick_extreme();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0;
      3: return ONE;
      4: return -ONE;
      default: return 32'hffff_ffff;
    endcase
  endfunction

  function automatic int jitter(input int amp);
    return int'($urandom_range(0, 2 * amp)) - amp;
  endfunction

  // Queue the first n_elems elements of a matrix; a full count makes a whole one.
  // Phase permutations are exactly unitary; the balanced kind mixes row pairs by 1/sqrt(2).
  task automatic queue_matrix(input int dim, input mat_kind_t kind, input int amp,
                              input int n_elems);
    int perm[8];
    int cre[8][8];
    int cim[8][8];
    int j, tmp, n;
    logic signed [ELEM_W-1:0] scale;
    elem_t e;
    for (int r = 0; r < dim; r++) perm[r] = r;
    for (int r = dim - 1; r > 0; r--) begin
      j = $urandom_range(r);
      tmp = perm[r];
      perm[r] = perm[j];
      perm[j] = tmp;
    end
    for (int r = 0; r < dim; r++) begin
      for (int c = 0; c < dim; c++) begin
        cre[r][c] = 0;
        cim[r][c] = 0;
      end
      case ($urandom_range(3))
        0: cre[r][perm[r]] = 1;
        1: cim[r][perm[r]] = 1;
        2: cre[r][perm[r]] = -1;
        default: cim[r][perm[r]] = -1;
      endcase
    end
    scale = ONE;
    if (kind == MAT_BALANCED && dim > 1) begin
      scale = HALF_SQRT2;
      for (int r = 0; r < dim; r += 2) begin
        for (int c = 0; c < dim; c++) begin
          tmp = cre[r][c];
          cre[r][c] = tmp + cre[r+1][c];
          cre[r+1][c] = tmp - cre[r+1][c];
          tmp = cim[r][c];
          cim[r][c] = tmp + cim[r+1][c];
          cim[r+1][c] = tmp - cim[r+1][c];
        end
      end
    end
    n = 0;
    for (int r = 0; r < dim; r++) begin
      for (int c = 0; c < dim; c++) begin
        if (n < n_elems) begin
          case (kind)
            MAT_NOISE: e = {$urandom, $urandom};
            MAT_EXTREME: begin
              e.re_part = pick_extreme();
              e.im_part = pick_extreme();
            end
            default: begin
              e.re_part = cre[r][c] * scale;
              e.im_part = cim[r][c] * scale;
              if (amp > 0 && $urandom_range(3) == 0) e.re_part = e.re_part + jitter(amp);
              if (amp > 0 && $urandom_range(3) == 0) e.im_part = e.im_part + jitter(amp);
            end
          endcase
          elem_q.push_back(e);
          items_queued++;
        end
        n++;
      end
    end
  endtask

  initial begin
    int phase, pick, qb, dim, n_mat, amp;
    logic [TOL_W-1:0] tol;
    mat_kind_t kind;

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    reg_check(REG_QUBITS);
    reg_check(REG_TOL);

    // 1x1: every element is a matrix; edges of the strict tolerance compare
    reg_write(REG_QUBITS, 0);
    queue_one(ONE, 32'h0);
    queue_one(32'h0, ONE);
    queue_one(ONE + 512, 32'h0);            // product off by exactly the tolerance: passes
    queue_one(ONE + 513, 32'h0);            // just past it
    queue_one(32'h8000_0000, 32'h7fff_ffff);
    queue_one(32'h7fff_ffff, 32'hffff_ffff);
    settle();

    // tolerance change mid-load keeps the partial matrix
    reg_write(REG_QUBITS, 1);
    queue_one(ONE, 32'h0);
    queue_one(32'h0, 32'h0);
    queue_one(32'h0, 32'h0);
    settle();
    reg_write(REG_TOL, 0);
    queue_one(ONE, 32'h0);
    settle();

    // size write mid-load drops the partial matrix
    queue_one(32'h8000_0000, 32'h8000_0000);
    queue_one(32'h7fff_ffff, 32'h7fff_ffff);
    settle();
    reg_write(REG_QUBITS, 1);
    queue_matrix(2, MAT_PHASE_PERM, 0, 4);
    settle();
    reg_check(REG_QUBITS);
    reg_check(REG_TOL);

    items_queued = 0;
    phase = 0;
    while (items_queued < 450) begin
      calm = (phase == 2);
      pick = $urandom_range(99);
      qb = (pick < 15) ? 0 : (pick < 50) ? 1 : (pick < 85) ? 2 : 3;
      reg_write(REG_QUBITS, qb);
      if (phase < 2 || $urandom_range(2) == 0) begin
        case (phase)
          0: tol = '0;
          1: tol = 31'd1073741824;
          default: begin
            case ($urandom_range(3))
              0: tol = TOL_RST;
              1: tol = TOL_W'($urandom_range(0, 4096));
              2: tol = TOL_W'($urandom_range(0, 1 << 20));
              default: tol = TOL_W'($urandom_range(0, 1 << 30));
            endcase
          end
        endcase
        reg_write(REG_TOL, tol);
      end
      dim = 1 << qb;
      case (qb)
        0: n_mat = $urandom_range(8, 20);
        1: n_mat = $urandom_range(3, 6);
        2: n_mat = $urandom_range(2, 3);
        default: n_mat = 1;
      endcase
      if (calm) n_mat = n_mat * 2;
      for (int m = 0; m < n_mat; m++) begin
        pick = $urandom_range(99);
        kind = (pick < 10) ? MAT_NOISE : (pick < 20) ? MAT_EXTREME :
               (pick < 60) ? MAT_PHASE_PERM : MAT_BALANCED;
        amp = 0;
        if ($urandom_range(9) >= 4)
          amp = (tol_cfg < (1 << 20)) ? int'(tol_cfg) * 3 / 2 + 4 : (1 << 21);
        queue_matrix(dim, kind, amp, dim * dim);
      end
      // now and then leave a partial matrix for the next size write to drop
      if (dim > 1 && $urandom_range(9) == 0)
        queue_matrix(dim, MAT_NOISE, 0, $urandom_range(1, dim * dim - 1));
      settle();
      if ($urandom_range(3) == 0) begin
        reg_check(REG_QUBITS);
        reg_check(REG_TOL);
      end
      phase++;
    end
    calm = 1'b0;

    settle();
    if (unitary_q.size() != 0)
      log_fail($sformatf("%0d flags never arrived", unitary_q.size()));
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/umc_pkg.sv
rtl/umc_ctrl.sv
rtl/umc_dp.sv
rtl/unitary_matrix_check_unit.sv
tb/tb.sv
